### design/lgg_pkg.sv
`timescale 1ns / 1ps

package lgg_pkg;

   // operation codes carried on req_func; code 3 is unused, changes nothing and returns a result of 0
   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_STEP  = 2'd2
   } func_type;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_CELL  = 8'b0000_0100,
      ST_GRD   = 8'b0000_1000,
      ST_GSHF  = 8'b0001_0000,
      ST_SWEEP = 8'b0010_0000,
      ST_GWR   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

endpackage

### design/life_grid_generation_step.sv
`timescale 1ns / 1ps
// Cell read or write: ST_CELL accesses the row, then ST_DONE registers the result.
// Generation step: rows are swept one cell per cycle through a single 8-input neighbor
// counter; each row costs a memory read, a window shift and a row write.
// One transaction at a time; a finished result may wait in the output register meanwhile.
// Reset (synchronous) clears control state, then a clear pass zeroes the rows of bank 0
// before the first transaction is taken.
module life_grid_generation_step
   import lgg_pkg::*;
#(
   parameter int ROWS = 20,
   parameter int COLS = 20
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [4:0] req_row,
   input  logic [4:0] req_col,
   input  logic       req_cell_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_cell_out
);

   localparam int RA = $clog2(ROWS);
   localparam int LW = $clog2(ROWS + 2);
   localparam int CW = $clog2(COLS + 1);

   // two banks of row words; generation reads one and writes the other
   logic [COLS-1:0] grid_mem [0:1][0:ROWS-1];

   state_type       state_ff, state_in;
   logic            bank_ff, bank_in;
   logic [RA-1:0]   out_row_ff, out_row_in;
   logic [LW-1:0]   ld_row_ff, ld_row_in;
   logic [CW-1:0]   ccnt_ff, ccnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_cell_ff, rsp_cell_in;

   logic [1:0]      func_ff, func_in;
   logic [4:0]      row_ff, row_in;
   logic [4:0]      col_ff, col_in;
   logic            val_ff, val_in;
   logic            inside_ff, inside_in;
   logic            res_ff, res_in;

   logic [COLS-1:0] prev_ff, prev_in;
   logic [COLS-1:0] cur_ff, cur_in;
   logic [COLS-1:0] nxt_ff, nxt_in;
   logic [COLS-1:0] new_row_ff, new_row_in;
   logic [2:0]      win_left_ff, win_left_in;
   logic [2:0]      win_ctr_ff, win_ctr_in;

   logic [COLS-1:0] rd_q_ff;
   logic            rd_en;
   logic [RA-1:0]   rd_row;
   logic            wr_en;
   logic            wr_bank;
   logic [RA-1:0]   wr_row;
   logic [COLS-1:0] wr_data;

   logic            req_take;
   logic            req_inside;
   logic            rsp_free;
   logic            ld_in_grid;
   logic [2:0]      win_new;
   logic [3:0]      nb_count;
   logic            cell_next;
   logic [COLS-1:0] cell_word;
   logic            cell_bit;

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_take     = req_valid && !req_stall;
   assign req_inside   = (int'(req_row) < ROWS) && (int'(req_col) < COLS);
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign ld_in_grid   = (ld_row_ff < LW'(ROWS));
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cell_out = rsp_cell_ff;

   // incoming column of the 3x3 window; past the last column it is the dead border
   assign win_new = (ccnt_ff < CW'(COLS)) ? {nxt_ff[0], cur_ff[0], prev_ff[0]} : 3'b000;

   // the shared neighbor counter
   assign nb_count = 4'(win_left_ff[0]) + 4'(win_left_ff[1]) + 4'(win_left_ff[2])
                   + 4'(win_ctr_ff[0]) + 4'(win_ctr_ff[2])
                   + 4'(win_new[0]) + 4'(win_new[1]) + 4'(win_new[2]);
   assign cell_next = (nb_count == 4'd3) || (win_ctr_ff[1] && (nb_count == 4'd2));

   always_comb begin
      cell_word = rd_q_ff;
      cell_bit  = 1'b0;
      for (int i = 0; i < COLS; i++) begin
         if (int'(col_ff) == i) begin
            cell_word[i] = val_ff;
            cell_bit     = rd_q_ff[i];
         end
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_row  = ld_row_ff[RA-1:0];
      wr_en   = 1'b0;
      wr_bank = bank_ff;
      wr_row  = out_row_ff;
      wr_data = cell_word;

      state_in     = state_ff;
      bank_in      = bank_ff;
      out_row_in   = out_row_ff;
      ld_row_in    = ld_row_ff;
      ccnt_in      = ccnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cell_in  = rsp_cell_ff;
      func_in      = func_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      val_in       = val_ff;
      inside_in    = inside_ff;
      res_in       = res_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      new_row_in   = new_row_ff;
      win_left_in  = win_left_ff;
      win_ctr_in   = win_ctr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_data    = '0;
            out_row_in = out_row_ff + 1'b1;
            if (out_row_ff == RA'(ROWS - 1)) begin
               out_row_in = '0;
               state_in   = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rd_row = RA'(req_row);
            rd_en  = req_take && req_inside;
            if (req_take) begin
               func_in   = req_func;
               row_in    = req_row;
               col_in    = req_col;
               val_in    = req_cell_in;
               inside_in = req_inside;
               res_in    = 1'b0;
               case (req_func)
                  FUNC_WRITE, FUNC_READ: begin
                     state_in = req_inside ? ST_CELL : ST_DONE;
                  end
                  FUNC_STEP: begin
                     prev_in    = '0;
                     cur_in     = '0;
                     nxt_in     = '0;
                     ld_row_in  = '0;
                     out_row_in = '0;
                     state_in   = ST_GRD;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_CELL: begin
            wr_row = RA'(row_ff);
            wr_en  = (func_ff == FUNC_WRITE);
            res_in = (func_ff == FUNC_READ) && cell_bit;
            state_in = ST_DONE;
         end
         ST_GRD: begin
            rd_en    = ld_in_grid;
            state_in = ST_GSHF;
         end
         ST_GSHF: begin
            prev_in   = cur_ff;
            cur_in    = nxt_ff;
            nxt_in    = ld_in_grid ? rd_q_ff : '0;
            ld_row_in = ld_row_ff + 1'b1;
            // first pass only primes the window with row 0
            if (ld_row_ff == '0) begin
               state_in = ST_GRD;
            end else begin
               ccnt_in     = '0;
               win_left_in = '0;
               win_ctr_in  = '0;
               state_in    = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            win_left_in = win_ctr_ff;
            win_ctr_in  = win_new;
            ccnt_in     = ccnt_ff + 1'b1;
            if (ccnt_ff != '0) begin
               new_row_in = {cell_next, new_row_ff[COLS-1:1]};
            end
            // rotate so the rows are back in place after COLS steps
            if (ccnt_ff < CW'(COLS)) begin
               prev_in = {prev_ff[0], prev_ff[COLS-1:1]};
               cur_in  = {cur_ff[0], cur_ff[COLS-1:1]};
               nxt_in  = {nxt_ff[0], nxt_ff[COLS-1:1]};
            end else begin
               state_in = ST_GWR;
            end
         end
         ST_GWR: begin
            wr_en   = 1'b1;
            wr_bank = !bank_ff;
            wr_data = new_row_ff;
            if (out_row_ff == RA'(ROWS - 1)) begin
               bank_in  = !bank_ff;
               state_in = ST_DONE;
            end else begin
               out_row_in = out_row_ff + 1'b1;
               state_in   = ST_GRD;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_bank][wr_row] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= grid_mem[bank_ff][rd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         bank_ff      <= 1'b0;
         out_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         out_row_ff   <= out_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ld_row_ff   <= ld_row_in;
      ccnt_ff     <= ccnt_in;
      rsp_cell_ff <= rsp_cell_in;
      func_ff     <= func_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      val_ff      <= val_in;
      inside_ff   <= inside_in;
      res_ff      <= res_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      new_row_ff  <= new_row_in;
      win_left_ff <= win_left_in;
      win_ctr_ff  <= win_ctr_in;
   end

   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != ST_IDLE))
      else $error("accepted transaction did not start work");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

   a_bank_flip: assert property (@(posedge clock) disable iff (reset)
      (bank_ff != $past(bank_ff)) |-> $past(state_ff == ST_GWR))
      else $error("bank changed outside the last row write");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (ccnt_ff <= CW'(COLS)))
      else $error("column counter ran past the grid");

   a_cell_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CELL) |-> (inside_ff && (func_ff == FUNC_WRITE || func_ff == FUNC_READ)))
      else $error("cell access outside the grid");

endmodule

### verif/life_grid_generation_step_test.sv
`timescale 1ns / 1ps

module life_grid_generation_step_test;
   import lgg_pkg::*;

   localparam int GRID_ROWS = 20;
   localparam int GRID_COLS = 20;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int IDLE_PCT = 35;
   localparam int RANDOM_ITEMS = 1000;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [1:0] func;
      logic [4:0] row;
      logic [4:0] col;
      logic       cell_in;
   } cell_op_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_func = FUNC_READ;
   logic [4:0] req_row = '0;
   logic [4:0] req_col = '0;
   logic       req_cell_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_cell_out;

   cell_op_type pending_ops_q[$];
   logic        expected_cell_q[$];
   bit          life_cells[GRID_ROWS][GRID_COLS];
   int          accepted_ops = 0;
   int          error_count = 0;
   int          quiet_cycles = 0;

   life_grid_generation_step uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_row      (req_row),
      .req_col      (req_col),
      .req_cell_in  (req_cell_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_cell_out (rsp_cell_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // B3/S23 neighbor count, dead border (no wrap)
   function automatic int live_neighbors(int r, int c);
      int sum;
      int rr;
      int cc;
      sum = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < GRID_ROWS && cc >= 0 && cc < GRID_COLS)
               sum += life_cells[rr][cc];
         end
      end
      return sum;
   endfunction

   // applies one transaction to the shadow grid, returns the expected cell_out
   function automatic logic life_apply(cell_op_type op);
      bit   nxt[GRID_ROWS][GRID_COLS];
      logic out_bit;
      logic on_grid;
      int   n;
      out_bit = 1'b0;
      on_grid = (op.row < GRID_ROWS) && (op.col < GRID_COLS);
      case (op.func)
         FUNC_WRITE: begin
            if (on_grid)
               life_cells[op.row][op.col] = op.cell_in;
         end
         FUNC_READ: begin
            if (on_grid)
               out_bit = life_cells[op.row][op.col];
         end
         FUNC_STEP: begin
            for (int r = 0; r < GRID_ROWS; r++) begin
               for (int c = 0; c < GRID_COLS; c++) begin
                  n = live_neighbors(r, c);
                  nxt[r][c] = life_cells[r][c] ? (n == 2 || n == 3) : (n == 3);
               end
            end
            life_cells = nxt;
         end
         default: ;
      endcase
      return out_bit;
   endfunction

   // a calm window in the middle of the run keeps both sides busy
   function automatic logic idle_now();
      if (accepted_ops >= 400 && accepted_ops < 600)
         return 1'b0;
      return $urandom_range(0, 99) < IDLE_PCT;
   endfunction

   // indexes wrap into the 5-bit fields: below 0 they land off the grid, past 31 they wrap modulo 32
   task automatic add_op(int func, int row, int col, int cell_in);
      cell_op_type op;
      op.func = 2'(func);
      op.row = 5'(row);
      op.col = 5'(col);
      op.cell_in = 1'(cell_in);
      pending_ops_q.push_back(op);
   endtask

   task automatic add_random_ops();
      int kind;
      int r0;
      int c0;
      int h;
      int w;
      int density;
      while (pending_ops_q.size() < RANDOM_ITEMS + 25) begin
         kind = $urandom_range(0, 99);
         if (kind < 12) begin
            // noise: any func, any index, including out of grid
            repeat ($urandom_range(1, 4))
               add_op($urandom_range(0, 3), $urandom_range(0, 31), $urandom_range(0, 31),
                      $urandom_range(0, 1));
         end else begin
            // seed a patch, run a few generations, probe around it
            r0 = $urandom_range(0, GRID_ROWS - 1);
            c0 = $urandom_range(0, GRID_COLS - 1);
            h = $urandom_range(2, 6);
            w = $urandom_range(2, 6);
            density = $urandom_range(25, 60);
            for (int i = 0; i < h; i++)
               for (int j = 0; j < w; j++)
                  add_op(FUNC_WRITE, r0 + i, c0 + j, $urandom_range(0, 99) < density);
            repeat ($urandom_range(1, 3))
               add_op(FUNC_STEP, $urandom_range(0, 31), $urandom_range(0, 31),
                      $urandom_range(0, 1));
            repeat ($urandom_range(4, 12))
               add_op(FUNC_READ, r0 + $urandom_range(0, h + 1) - 1,
                      c0 + $urandom_range(0, w + 1) - 1, $urandom_range(0, 1));
         end
      end
   endtask

   initial begin
      // corners, out-of-grid indexes, unused func, a column-0 line across a step
      add_op(FUNC_READ, 0, 0, 1'b0);
      add_op(FUNC_WRITE, 0, 0, 1'b1);
      add_op(FUNC_WRITE, 19, 19, 1'b1);
      add_op(FUNC_WRITE, 0, 19, 1'b1);
      add_op(FUNC_WRITE, 19, 0, 1'b1);
      add_op(FUNC_READ, 0, 0, 1'b0);
      add_op(FUNC_READ, 19, 19, 1'b1);
      add_op(FUNC_READ, 0, 19, 1'b0);
      add_op(FUNC_READ, 19, 0, 1'b1);
      add_op(FUNC_WRITE, 31, 31, 1'b1);
      add_op(FUNC_WRITE, 20, 0, 1'b1);
      add_op(FUNC_WRITE, 0, 20, 1'b1);
      add_op(FUNC_READ, 31, 31, 1'b1);
      add_op(FUNC_READ, 20, 0, 1'b0);
      add_op(FUNC_READ, 0, 20, 1'b1);
      add_op(FUNC_UNUSED, 0, 0, 1'b0);
      add_op(FUNC_READ, 0, 0, 1'b0);
      add_op(FUNC_WRITE, 1, 0, 1'b1);
      add_op(FUNC_WRITE, 2, 0, 1'b1);
      add_op(FUNC_STEP, 31, 31, 1'b1);
      add_op(FUNC_READ, 1, 1, 1'b0);
      add_op(FUNC_READ, 1, 0, 1'b0);
      add_op(FUNC_READ, 0, 0, 1'b0);
      add_random_ops();

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      do
         @(posedge clock);
      while (pending_ops_q.size() != 0 || req_valid || expected_cell_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // driver: predict on acceptance, then present the next pending transaction
   always @(posedge clock) begin : drive
      cell_op_type op;
      logic        send;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            expected_cell_q.push_back(life_apply({req_func, req_row, req_col, req_cell_in}));
            accepted_ops++;
         end
         send = (pending_ops_q.size() != 0) && !idle_now();
         if (send) begin
            op = pending_ops_q.pop_front();
            req_func <= op.func;
            req_row <= op.row;
            req_col <= op.col;
            req_cell_in <= op.cell_in;
         end
         req_valid <= send;
      end
   end

   // monitor: compare each result with the oldest expected cell value
   always @(posedge clock) begin : check
      logic want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cell_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual cell_out=%0b",
                        $time, rsp_cell_out);
               error_count++;
            end else begin
               want = expected_cell_q.pop_front();
               if (rsp_cell_out !== want) begin
                  $display("%0t: cell_out mismatch, expected %0b, actual %0b",
                           $time, want, rsp_cell_out);
                  error_count++;
               end
            end
         end
         rsp_stall <= idle_now();
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

endmodule
